/* rtl/tnbu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnbu_pkg: shared types and arithmetic for the tanh neuron backprop unit
// Codes, queue entry type, sequencer states, tanh table and saturation.
// ----------------------------------------------------------------------------
package tnbu_pkg;

   localparam int DEF_MAX_INPUTS = 64;
   localparam int QDEPTH         = 2;

   localparam logic [16:0] LR_RESET  = 17'd9830;
   localparam logic [16:0] MOM_RESET = 17'd32768;

   // Request mode codes
   localparam logic [2:0] MODE_LOAD  = 3'd0;
   localparam logic [2:0] MODE_FWD   = 3'd1;
   localparam logic [2:0] MODE_OGRAD = 3'd2;
   localparam logic [2:0] MODE_HGRAD = 3'd3;
   localparam logic [2:0] MODE_UPD   = 3'd4;

   // Result kind codes
   localparam logic [1:0] KIND_ACT    = 2'd0;
   localparam logic [1:0] KIND_GRAD   = 2'd1;
   localparam logic [1:0] KIND_WEIGHT = 2'd2;

   // Configuration register indexes
   localparam logic CSR_LR  = 1'b0;
   localparam logic CSR_MOM = 1'b1;

   localparam logic signed [33:0] ONE_Q16    = 34'sd65536;
   localparam logic [47:0]        TANH_LIMIT = 48'd393216;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_FWD,
      OP_OGRAD,
      OP_HGRAD,
      OP_UPD
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [5:0]         index;
      logic               ok;
      logic signed [31:0] value;
      logic signed [31:0] dgrad;
      logic               last;
   } q_item_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FMUL,
      S_HMUL,
      S_ACC,
      S_TMUL,
      S_TFIN,
      S_DMUL,
      S_DFIN,
      S_GMUL,
      S_GFIN,
      S_UMUL,
      S_UP,
      S_UETA,
      S_UALPHA,
      S_UFIN,
      S_UWR
   } state_type;

   // round(65536*tanh(k/4)), k = 0..24
   function automatic logic [16:0] tanh_lut(input logic [4:0] k);
      logic [16:0] r;
      unique case (k)
         5'd0:  r = 17'd0;
         5'd1:  r = 17'd16051;
         5'd2:  r = 17'd30285;
         5'd3:  r = 17'd41625;
         5'd4:  r = 17'd49912;
         5'd5:  r = 17'd55593;
         5'd6:  r = 17'd59320;
         5'd7:  r = 17'd61694;
         5'd8:  r = 17'd63178;
         5'd9:  r = 17'd64096;
         5'd10: r = 17'd64659;
         5'd11: r = 17'd65000;
         5'd12: r = 17'd65212;
         5'd13: r = 17'd65339;
         5'd14: r = 17'd65417;
         5'd15: r = 17'd65464;
         5'd16: r = 17'd65492;
         5'd17: r = 17'd65509;
         5'd18: r = 17'd65520;
         5'd19: r = 17'd65526;
         5'd20: r = 17'd65530;
         5'd21: r = 17'd65532;
         5'd22: r = 17'd65534;
         5'd23: r = 17'd65535;
         5'd24: r = 17'd65535;
         default: r = 17'd65535;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = signed'(v[31:0]);
      end
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [67:0] v);
      logic signed [47:0] r;
      if (v > 68'sh7fffffffffff) begin
         r = 48'sh7fffffffffff;
      end else if (v < -68'sh800000000000) begin
         r = 48'sh800000000000;
      end else begin
         r = signed'(v[47:0]);
      end
      return r;
   endfunction

endpackage

/* rtl/tanh_neuron_backprop_unit_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_neuron_backprop_unit_core: one tanh neuron with backprop and momentum
// Signed Q16.16 forward pass, gradients and momentum weight update.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_* (valid/stall); a transaction is taken at a clock
//   edge with req_valid high and req_stall low. Results leave on rsp_* the
//   same way. Training rate and momentum are written through csr_* while the
//   block is idle; the user must keep to this, the block does not enforce it.
//   The front classifies each request and drops no-op transactions (unused
//   modes, loads and updates beyond the weight store); the rest wait in a
//   two-entry queue for the back-end sequencer, which shares one registered
//   multiplier and runs one transaction at a time; the queue lets intake
//   run ahead by two transactions.
//   Results sit in an output register: a stalled receiver holds it and the
//   sequencer waits at its final step, while intake continues until the
//   queue fills. Reset clears the queue, sequencer, accumulator, activation,
//   gradient and momentum history and restores the default rate and
//   momentum. Weights are undefined until loaded.
// ----------------------------------------------------------------------------
module tanh_neuron_backprop_unit_core
   import tnbu_pkg::*;
#(
   parameter int MAX_INPUTS = DEF_MAX_INPUTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [5:0]         req_index,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_downstream_gradient,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_result_kind,
   output logic [5:0]         rsp_result_index,
   output logic signed [31:0] rsp_result_value,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [16:0]        csr_wdata
);

   // Configuration registers: eta and alpha, both unsigned Q1.16, used as written
   logic [16:0] lr_ff;
   logic [16:0] mom_ff;

   logic       q_valid;
   q_item_type q_item;
   logic       q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= LR_RESET;
         mom_ff <= MOM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LR:  lr_ff  <= csr_wdata;
            CSR_MOM: mom_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Intake and classification, with the queue toward the sequencer
   tnbu_front #(.MAX_INPUTS(MAX_INPUTS)) u_front (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_mode                (req_mode),
      .req_index               (req_index),
      .req_value               (req_value),
      .req_downstream_gradient (req_downstream_gradient),
      .req_last                (req_last),
      .q_valid                 (q_valid),
      .q_item                  (q_item),
      .q_pop                   (q_pop)
   );

   // Sequencer, stores and result register
   tnbu_back #(.MAX_INPUTS(MAX_INPUTS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .learning_rate    (lr_ff),
      .momentum         (mom_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_index (rsp_result_index),
      .rsp_result_value (rsp_result_value)
   );

endmodule

/* rtl/tnbu_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnbu_ram: generic single-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tnbu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/tnbu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnbu_front: request intake and classification
// Decodes mode, checks the index range, drops no-op requests and queues
// the rest for the execution sequencer.
// ----------------------------------------------------------------------------
module tnbu_front
   import tnbu_pkg::*;
#(
   parameter int MAX_INPUTS = DEF_MAX_INPUTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [5:0]         req_index,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_downstream_gradient,
   input  logic               req_last,
   output logic               q_valid,
   output q_item_type         q_item,
   input  logic               q_pop
);

   localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCW = $clog2(QDEPTH + 1);

   q_item_type     q_ff [QDEPTH];
   logic [QAW-1:0] wptr_ff, wptr_in;
   logic [QAW-1:0] rptr_ff, rptr_in;
   logic [QCW-1:0] count_ff, count_in;

   q_item_type entry;
   logic       keep;
   logic       push;

   // classify
   always_comb begin
      entry.index = req_index;
      entry.ok    = (32'(req_index) < MAX_INPUTS);
      entry.value = req_value;
      entry.dgrad = req_downstream_gradient;
      entry.last  = req_last;
      unique case (req_mode)
         MODE_LOAD: begin
            entry.op = OP_LOAD;
            keep     = entry.ok;
         end
         MODE_FWD: begin
            entry.op = OP_FWD;
            keep     = 1'b1;
         end
         MODE_OGRAD: begin
            entry.op = OP_OGRAD;
            keep     = 1'b1;
         end
         MODE_HGRAD: begin
            entry.op = OP_HGRAD;
            keep     = 1'b1;
         end
         MODE_UPD: begin
            entry.op = OP_UPD;
            keep     = entry.ok;
         end
         default: begin
            entry.op = OP_LOAD;
            keep     = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == QCW'(QDEPTH));
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == QAW'(QDEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (q_pop) begin
         rptr_in = (rptr_ff == QAW'(QDEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= entry;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCW'(QDEPTH))
      else $error("queue count above depth");

   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");

endmodule

/* rtl/tnbu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnbu_back: execution sequencer
// Runs one queued operation at a time over a shared registered multiplier,
// owns the weight and delta stores, neuron state and the result register.
// ----------------------------------------------------------------------------
module tnbu_back
   import tnbu_pkg::*;
#(
   parameter int MAX_INPUTS = DEF_MAX_INPUTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  q_item_type         q_item,
   output logic               q_pop,
   input  logic [16:0]        learning_rate,
   input  logic [16:0]        momentum,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_result_kind,
   output logic [5:0]         rsp_result_index,
   output logic signed [31:0] rsp_result_value
);

   localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

   state_type state_ff, state_in;

   q_item_type         cur_ff;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [31:0] act_ff, act_in;
   logic signed [31:0] grad_ff, grad_in;
   logic signed [67:0] prod_ff;
   logic signed [33:0] tmp_ff, tmp_in;
   logic signed [33:0] sum_ff, sum_in;
   logic               neg_ff, neg_in;
   logic               big_ff, big_in;
   logic [MAX_INPUTS-1:0] dvalid_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_kind_ff;
   logic [5:0]         rsp_index_ff;
   logic signed [31:0] rsp_value_ff;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_in;
   logic               prod_hold;
   logic               out_free;
   logic               emit;
   logic [1:0]         emit_kind;
   logic [5:0]         emit_index;
   logic signed [31:0] emit_value;

   logic [AW-1:0]      raddr, waddr;
   logic               w_we, d_we;
   logic signed [31:0] w_wdata;
   logic signed [31:0] w_rdata, d_rdata;
   logic signed [31:0] old_delta;
   logic               dclr;

   logic [47:0]        ax;
   logic [16:0]        lo, hi;
   logic signed [33:0] ysum;
   logic signed [31:0] new_w;

   tnbu_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS)) u_weight (
      .clock (clock),
      .we    (w_we),
      .waddr (waddr),
      .wdata (w_wdata),
      .raddr (raddr),
      .rdata (w_rdata)
   );

   tnbu_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS)) u_delta (
      .clock (clock),
      .we    (d_we),
      .waddr (waddr),
      .wdata (tmp_ff[31:0]),
      .raddr (raddr),
      .rdata (d_rdata)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign old_delta = dvalid_ff[AW'(cur_ff.index)] ? d_rdata : 32'sd0;

   // hold the product while a finished result waits for the output register
   assign prod_hold = ((state_ff == S_TFIN) || (state_ff == S_GFIN)) && !out_free;

   assign ax   = acc_ff[47] ? 48'(-acc_ff) : 48'(acc_ff);
   assign lo   = tanh_lut(ax[18:14]);
   assign hi   = tanh_lut(5'(ax[18:14] + 5'd1));
   assign ysum = tmp_ff + 34'(prod_ff >>> 14);
   assign new_w = sat32(68'(w_rdata) + 68'(tmp_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               unique case (q_item.op)
                  OP_LOAD:  state_in = S_IDLE;
                  OP_FWD:   state_in = S_FMUL;
                  OP_OGRAD: state_in = S_DMUL;
                  OP_HGRAD: state_in = S_HMUL;
                  OP_UPD:   state_in = S_UMUL;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_FMUL:   state_in = S_ACC;
         S_HMUL:   state_in = S_ACC;
         S_ACC: begin
            if (!cur_ff.last) begin
               state_in = S_IDLE;
            end else if (cur_ff.op == OP_FWD) begin
               state_in = S_TMUL;
            end else begin
               state_in = S_DMUL;
            end
         end
         S_TMUL:   state_in = S_TFIN;
         S_TFIN:   state_in = out_free ? S_IDLE : S_TFIN;
         S_DMUL:   state_in = S_DFIN;
         S_DFIN:   state_in = S_GMUL;
         S_GMUL:   state_in = S_GFIN;
         S_GFIN:   state_in = out_free ? S_IDLE : S_GFIN;
         S_UMUL:   state_in = S_UP;
         S_UP:     state_in = S_UETA;
         S_UETA:   state_in = S_UALPHA;
         S_UALPHA: state_in = S_UFIN;
         S_UFIN:   state_in = S_UWR;
         S_UWR:    state_in = out_free ? S_IDLE : S_UWR;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop      = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      w_we       = 1'b0;
      d_we       = 1'b0;
      dclr       = 1'b0;
      w_wdata    = new_w;
      raddr      = AW'(cur_ff.index);
      waddr      = AW'(cur_ff.index);
      emit       = 1'b0;
      emit_kind  = KIND_ACT;
      emit_index = '0;
      emit_value = act_in;
      unique case (state_ff)
         S_IDLE: begin
            raddr = AW'(q_item.index);
            waddr = AW'(q_item.index);
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.op == OP_LOAD) begin
                  w_we    = 1'b1;
                  w_wdata = q_item.value;
                  dclr    = 1'b1;
               end
            end
         end
         S_FMUL: begin
            mul_a = 34'(cur_ff.value);
            mul_b = cur_ff.ok ? 34'(w_rdata) : 34'sd0;
         end
         S_HMUL: begin
            mul_a = 34'(cur_ff.value);
            mul_b = 34'(cur_ff.dgrad);
         end
         S_TMUL: begin
            mul_a = signed'(34'(hi)) - signed'(34'(lo));
            mul_b = signed'(34'(ax[13:0]));
         end
         S_TFIN: begin
            emit      = out_free;
            emit_kind = KIND_ACT;
         end
         S_DMUL: begin
            mul_a = 34'(act_ff);
            mul_b = 34'(act_ff);
         end
         S_GMUL: begin
            mul_a = (cur_ff.op == OP_OGRAD) ? 34'(cur_ff.value) - 34'(act_ff)
                                            : 34'(sat32(68'(acc_ff)));
            mul_b = tmp_ff;
         end
         S_GFIN: begin
            emit       = out_free;
            emit_kind  = KIND_GRAD;
            emit_value = grad_in;
         end
         S_UMUL: begin
            mul_a = 34'(cur_ff.value);
            mul_b = 34'(grad_ff);
         end
         S_UETA: begin
            mul_a = tmp_ff;
            mul_b = signed'(34'(learning_rate));
         end
         S_UALPHA: begin
            mul_a = 34'(old_delta);
            mul_b = signed'(34'(momentum));
         end
         S_UWR: begin
            emit       = out_free;
            emit_kind  = KIND_WEIGHT;
            emit_index = cur_ff.index;
            emit_value = new_w;
            w_we       = out_free;
            d_we       = out_free;
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // datapath next values
   always_comb begin
      acc_in  = acc_ff;
      act_in  = act_ff;
      grad_in = grad_ff;
      tmp_in  = tmp_ff;
      sum_in  = sum_ff;
      neg_in  = neg_ff;
      big_in  = big_ff;
      unique case (state_ff)
         S_ACC: begin
            acc_in = sat48(68'(acc_ff) + (prod_ff >>> 16));
         end
         S_TMUL: begin
            neg_in = acc_ff[47];
            big_in = (ax >= TANH_LIMIT);
            tmp_in = signed'(34'(lo));
         end
         S_TFIN: begin
            act_in = neg_ff ? 32'(-(big_ff ? ONE_Q16 : ysum))
                            : 32'(big_ff ? ONE_Q16 : ysum);
            if (out_free) begin
               acc_in = '0;
            end
         end
         S_DFIN: begin
            tmp_in = ONE_Q16 - 34'(prod_ff >>> 16);
         end
         S_GFIN: begin
            grad_in = sat32(prod_ff >>> 16);
            if (out_free && cur_ff.op == OP_HGRAD) begin
               acc_in = '0;
            end
         end
         S_UP: begin
            tmp_in = 34'(sat32(prod_ff >>> 16));
         end
         S_UALPHA: begin
            sum_in = 34'(prod_ff >>> 16);
         end
         S_UFIN: begin
            tmp_in = 34'(sat32(68'(sum_ff) + (prod_ff >>> 16)));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         act_ff       <= '0;
         grad_ff      <= '0;
         dvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         act_ff   <= act_in;
         grad_ff  <= grad_in;
         if (dclr) begin
            dvalid_ff[waddr] <= 1'b0;
         end else if (d_we) begin
            dvalid_ff[waddr] <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!prod_hold) begin
         prod_ff <= prod_in;
      end
      tmp_ff  <= tmp_in;
      sum_ff  <= sum_in;
      neg_ff  <= neg_in;
      big_ff  <= big_in;
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (emit) begin
         rsp_kind_ff  <= emit_kind;
         rsp_index_ff <= emit_index;
         rsp_value_ff <= emit_value;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE)
      else $error("queue popped while an operation is running");

   a_act_range: assert property (@(posedge clock) disable iff (reset)
      act_ff <= 32'sd65536 && act_ff >= -32'sd65536)
      else $error("activation outside unit range");

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TFIN && out_free) |=> acc_ff == 48'sd0)
      else $error("accumulator not cleared after activation");

endmodule

/* test/tanh_neuron_backprop_unit_core_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_neuron_backprop_unit_core_checker: result predictor and scoreboard
// Watches requests, results and register writes, predicts each result in
// Q16.16 and compares it field by field with what the neuron delivers.
// ----------------------------------------------------------------------------
module tanh_neuron_backprop_unit_core_checker
   import tnbu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [5:0]         req_index,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_downstream_gradient,
   input  logic               req_last,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_result_kind,
   input  logic [5:0]         rsp_result_index,
   input  logic signed [31:0] rsp_result_value,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [16:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [1:0]         kind;
      logic [5:0]         index;
      logic signed [31:0] value;
   } neuron_result_type;

   localparam wide_type MAX32 = 2147483647;
   localparam wide_type MIN32 = -(MAX32 + 1);
   localparam wide_type MAX48 = 48'h7fff_ffff_ffff;
   localparam wide_type MIN48 = -(MAX48 + 1);
   localparam wide_type UNITY = 65536;

   int tanh_points[25] = '{
      0, 16051, 30285, 41625, 49912, 55593, 59320, 61694, 63178,
      64096, 64659, 65000, 65212, 65339, 65417, 65464, 65492,
      65509, 65520, 65526, 65530, 65532, 65534, 65535, 65535
   };

   logic signed [31:0] weights [64];
   logic signed [31:0] deltas  [64];
   wide_type acc, act, grad, rate, mom;
   neuron_result_type expected_q [$];

   function automatic wide_type floor16(input wide_type v);
      return v >>> 16;
   endfunction

   function automatic wide_type clip32(input wide_type v);
      return (v > MAX32) ? MAX32 : (v < MIN32) ? MIN32 : v;
   endfunction

   function automatic wide_type clip48(input wide_type v);
      return (v > MAX48) ? MAX48 : (v < MIN48) ? MIN48 : v;
   endfunction

   function automatic wide_type tanh_q16(input wide_type x);
      wide_type ax, y, lo, hi, frac;
      int    i;
      ax = (x < 0) ? -x : x;
      if (ax >= 6 * UNITY) begin
         y = UNITY;
      end else begin
         i    = int'(ax >>> 14);
         frac = ax & 16383;
         lo   = tanh_points[i];
         hi   = tanh_points[i + 1];
         y    = lo + (((hi - lo) * frac) >>> 14);
      end
      return (x < 0) ? -y : y;
   endfunction

   function automatic wide_type slope();
      return UNITY - floor16(act * act);
   endfunction

   task automatic expect_result(input logic [1:0] kind, input logic [5:0] idx,
                                input wide_type v);
      neuron_result_type r;
      r.kind  = kind;
      r.index = idx;
      r.value = v[31:0];
      expected_q.push_back(r);
   endtask

   task automatic neuron_step(input logic [2:0] mode, input logic [5:0] idx,
                              input logic signed [31:0] val,
                              input logic signed [31:0] dg, input logic last);
      wide_type v, w, p, d, nd, nw;
      v = val;
      case (mode)
         MODE_LOAD: begin
            weights[idx] = val;
            deltas[idx]  = '0;
         end
         MODE_FWD: begin
            w   = weights[idx];
            acc = clip48(acc + floor16(v * w));
            if (last) begin
               act = tanh_q16(acc);
               acc = 0;
               expect_result(KIND_ACT, '0, act);
            end
         end
         MODE_OGRAD: begin
            grad = clip32(floor16((v - act) * slope()));
            expect_result(KIND_GRAD, '0, grad);
         end
         MODE_HGRAD: begin
            w   = dg;
            acc = clip48(acc + floor16(v * w));
            if (last) begin
               grad = clip32(floor16(clip32(acc) * slope()));
               acc  = 0;
               expect_result(KIND_GRAD, '0, grad);
            end
         end
         MODE_UPD: begin
            p  = clip32(floor16(v * grad));
            w  = deltas[idx];
            d  = floor16(p * rate) + floor16(w * mom);
            nd = clip32(d);
            w  = weights[idx];
            nw = clip32(w + nd);
            deltas[idx]  = nd[31:0];
            weights[idx] = nw[31:0];
            expect_result(KIND_WEIGHT, idx, nw);
         end
         default: ;  // unused modes leave everything alone
      endcase
   endtask

   always @(posedge clock) begin
      neuron_result_type e;
      if (reset) begin
         foreach (deltas[i]) deltas[i] = '0;
         acc  = 0;
         act  = 0;
         grad = 0;
         rate = LR_RESET;
         mom  = MOM_RESET;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_LR) rate = csr_wdata;
            else                     mom  = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result: kind %0d index %0d value %0d",
                      rsp_result_kind, rsp_result_index, rsp_result_value);
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_result_kind !== e.kind) begin
                  $error("result_kind expected %0d actual %0d", e.kind, rsp_result_kind);
                  fail_count++;
               end
               if (rsp_result_index !== e.index) begin
                  $error("result_index expected %0d actual %0d", e.index,
                         rsp_result_index);
                  fail_count++;
               end
               if (rsp_result_value !== e.value) begin
                  $error("result_value expected %0d actual %0d", e.value,
                         rsp_result_value);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            neuron_step(req_mode, req_index, req_value, req_downstream_gradient, req_last);
      end
      pending = expected_q.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end

endmodule

/* test/tanh_neuron_backprop_unit_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_neuron_backprop_unit_core_tb: stimulus and verdict for the neuron
// Drives directed corner cases, then random training traffic with unused
// modes and broken sequences under several idle and stall mixes and register
// settings; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tanh_neuron_backprop_unit_core_tb;
   import tnbu_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int NUM_PHASES     = 6;
   localparam int PRESSURE_PHASE = 4;
   localparam int PHASE_ITEMS    = 175;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_mode;
   logic [5:0]         req_index;
   logic signed [31:0] req_value;
   logic signed [31:0] req_downstream_gradient;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_result_kind;
   logic [5:0]         rsp_result_index;
   logic signed [31:0] rsp_result_value;
   logic               csr_write_enable;
   logic               csr_index;
   logic [16:0]        csr_wdata;

   int fail_count;
   int pending;

   // traffic shaping and run state, read by the sender, receiver and watchdog
   int idle_pct;
   int stall_pct;
   int phase;
   int items_sent;
   int hold_count;
   int quiet_cycles;
   logic [63:0] loaded;

   int idle_mix  [NUM_PHASES] = '{0, 79, 0, 29, 0, 79};
   int stall_mix [NUM_PHASES] = '{0, 0, 79, 29, 0, 79};
   int rate_mix  [NUM_PHASES] = '{9830, 0, 65536, 131071, 4000, 20000};
   int mom_mix   [NUM_PHASES] = '{32768, 65536, 0, 131071, 60000, 1000};

   tanh_neuron_backprop_unit_core DUT (.*);

   tanh_neuron_backprop_unit_core_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stall, plus one long hold-off at the start of the
   // pressure phase so the queue fills and the block stalls its input.
   always @(posedge clock) begin
      if (phase == PRESSURE_PHASE && hold_count < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_count++;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Offer one transaction and hold it until accepted.
   task automatic send(input logic [2:0] mode, input logic [5:0] idx,
                       input logic signed [31:0] val,
                       input logic signed [31:0] dg, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_mode                <= mode;
      req_index               <= idx;
      req_value               <= val;
      req_downstream_gradient <= dg;
      req_last                <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (mode <= MODE_UPD) items_sent++;
      if (mode == MODE_LOAD) loaded[idx] = 1'b1;
   endtask

   // Mix of full-range, Q16.16-scale and extreme values.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(4))
         0:       return $urandom;
         1:       return $urandom_range(262143) - 131072;
         2:       return $urandom_range(2097151) - 1048576;
         3: begin
            case ($urandom_range(4))
               0:       return 32'sh7fffffff;
               1:       return 32'sh80000000;
               2:       return 32'sd65536;
               3:       return -32'sd65536;
               default: return '0;
            endcase
         end
         default: return $urandom_range(32767) - 16384;
      endcase
   endfunction

   // Only loaded weights may be read.
   function automatic logic [5:0] pick_loaded();
      logic [5:0] idx;
      idx = 6'($urandom);
      while (!loaded[idx]) idx = idx + 6'd1;
      return idx;
   endfunction

   task automatic random_traffic(input int quota);
      int n;
      int target;
      target = items_sent + quota;
      while (items_sent < target) begin
         n = $urandom_range(6);
         case ($urandom_range(9))
            0, 1: send(MODE_LOAD, 6'($urandom), pick_value(), $urandom, 1'($urandom));
            2, 3: begin
               // forward pass over several connections
               for (int k = 0; k <= n; k++)
                  send(MODE_FWD, pick_loaded(), pick_value(), $urandom, k == n);
            end
            4: send(MODE_OGRAD, 6'($urandom), pick_value(), $urandom, 1'($urandom));
            5: begin
               for (int k = 0; k <= n; k++)
                  send(MODE_HGRAD, 6'($urandom), pick_value(), pick_value(), k == n);
            end
            6, 7: begin
               for (int k = 0; k <= n; k++)
                  send(MODE_UPD, pick_loaded(), pick_value(), $urandom, 1'($urandom));
            end
            8: send(3'(MODE_UPD + 1 + $urandom_range(2)), 6'($urandom), $urandom,
                    $urandom, 1'($urandom));
            default: begin
               // broken sequence: forward and hidden elements interleaved
               for (int k = 0; k <= n; k++) begin
                  if ($urandom_range(1))
                     send(MODE_FWD, pick_loaded(), pick_value(), $urandom,
                          $urandom_range(3) == 0);
                  else
                     send(MODE_HGRAD, 6'($urandom), pick_value(), pick_value(),
                          $urandom_range(3) == 0);
               end
            end
         endcase
      end
   endtask

   // Wait for every outstanding result, plus headroom for silent work.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [16:0] rate, input logic [16:0] mom);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_LR;
      csr_wdata        <= rate;
      @(posedge clock);
      csr_index        <= CSR_MOM;
      csr_wdata        <= mom;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      req_valid               <= 1'b0;
      req_mode                <= MODE_LOAD;
      req_index               <= '0;
      req_value               <= '0;
      req_downstream_gradient <= '0;
      req_last                <= 1'b0;
      csr_write_enable        <= 1'b0;
      csr_index               <= CSR_LR;
      csr_wdata               <= '0;
      rsp_stall               <= 1'b0;
      idle_pct   = 0;
      stall_pct  = 0;
      phase      = 0;
      items_sent = 0;
      hold_count = 0;
      loaded     = '0;
      reset      <= 1'b1;
      repeat (2) @(posedge clock);
      reset      <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         phase     = ph;
         idle_pct  = idle_mix[ph];
         stall_pct = stall_mix[ph];
         write_regs(17'(rate_mix[ph]), 17'(mom_mix[ph]));
         if (ph == 0) begin
            // directed corners: extreme weights, saturating sums, tanh edges
            send(MODE_LOAD, 6'd0, 32'sh7fffffff, '0, 1'b0);
            send(MODE_LOAD, 6'd63, 32'sh80000000, '0, 1'b0);
            send(MODE_LOAD, 6'd1, 32'sd65536, '0, 1'b0);
            send(MODE_FWD, 6'd0, 32'sh7fffffff, '0, 1'b0);
            send(MODE_FWD, 6'd0, 32'sh7fffffff, '0, 1'b1);
            send(MODE_FWD, 6'd63, 32'sh7fffffff, '0, 1'b1);
            send(MODE_FWD, 6'd1, 32'sd393216, '0, 1'b1);
            send(MODE_FWD, 6'd1, 32'sd393215, '0, 1'b1);
            send(MODE_FWD, 6'd1, -32'sd393216, '0, 1'b1);
            send(MODE_FWD, 6'd1, 32'sd20000, '0, 1'b1);
            send(MODE_OGRAD, '0, 32'sh7fffffff, '0, 1'b0);
            send(MODE_OGRAD, '0, 32'sh80000000, '0, 1'b0);
            send(MODE_HGRAD, '0, 32'sh80000000, 32'sh80000000, 1'b1);
            send(MODE_HGRAD, '0, 32'sh7fffffff, 32'sh80000000, 1'b1);
            // shared accumulator: hidden element lands inside a forward sum
            send(MODE_FWD, 6'd1, 32'sd65536, '0, 1'b0);
            send(MODE_HGRAD, '0, 32'sd32768, 32'sd65536, 1'b0);
            send(MODE_FWD, 6'd1, 32'sd16384, '0, 1'b1);
            send(MODE_OGRAD, '0, 32'sd65536, '0, 1'b0);
            send(MODE_UPD, 6'd0, 32'sh7fffffff, '0, 1'b0);
            send(MODE_UPD, 6'd0, 32'sh7fffffff, '0, 1'b0);
            send(MODE_UPD, 6'd63, 32'sh80000000, '0, 1'b0);
            send(MODE_UPD, 6'd1, 32'sd65536, '0, 1'b0);
            send(3'(MODE_UPD + 1), 6'd5, '1, '1, 1'b1);
            send(3'(MODE_UPD + 3), 6'd7, '0, '0, 1'b0);
         end
         random_traffic(PHASE_ITEMS);
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
